// File: src/wildcard_byte_signature_scan_top_assert.svh
// assertion macros for the wildcard byte signature scanner
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_TOP_ASSERT_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define WBSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WBSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/wbss_pkg.sv
// shared types and constants of the wildcard byte signature scanner
package wbss_pkg;

	localparam int MAX_PATTERN = 32;
	localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN) + 1;
	localparam int ADDR_W      = 32;
	localparam int OFFS_W      = 5;
	localparam int OPERAND_BYTES = 4;

	// register index, taken from paddr[5:3]
	typedef enum logic [2:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_SECOND = 3'd1,
		REG_PATTERN_THIRD  = 3'd2,
		REG_PATTERN_HIGH   = 3'd3,
		REG_WILDCARD_MASK  = 3'd4,
		REG_PATTERN_LENGTH = 3'd5,
		REG_OPERAND_OFFSET = 3'd6,
		REG_RELATIVE_MODE  = 3'd7
	} reg_idx_t;

	// configuration as seen by the compare unit
	typedef struct packed {
		logic [MAX_PATTERN*8-1:0] pattern;
		logic [MAX_PATTERN-1:0]   wild;
		logic [LEN_W-1:0]         eff_len;  // 1 .. MAX_PATTERN
		logic [OFFS_W-1:0]        offset;
		logic                     relative;
	} scan_cfg_t;

	// outcome of one compare
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] op_addr;
		logic [31:0]       op_value;
	} match_res_t;

endpackage

// File: src/wildcard_byte_signature_scan_top.sv
// top level of the wildcard byte signature scanner: config, window, result register
// path: an accepted byte is registered in s1 and its result in the output register
// throughput: one byte per cycle while results drain, set by the single compare
//   stage between s1 and the output register; a waiting result stalls a full s1
// reset: arst_n clears the pipeline valids, scan count and match flag at once; config
//   registers return to zero with pattern_length 1
module wildcard_byte_signature_scan_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_byte[7:0], byte_address[39:8]
	input  logic        s_tlast,   // last_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // operand_address[31:0], operand_value[63:32]
	output logic        m_tuser,   // found
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	`include "wildcard_byte_signature_scan_top_assert.svh"

	// ---------------- config registers ----------------
	logic [63:0]                   pat_q [4];
	logic [31:0]                   wild_q;
	logic [wbss_pkg::LEN_W-1:0]    len_q;
	logic [wbss_pkg::OFFS_W-1:0]   offset_q;
	logic                          relative_q;
	wbss_pkg::reg_idx_t            reg_idx;
	logic                          cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = wbss_pkg::reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) pat_q[r] <= '0;
			wild_q     <= '0;
			len_q      <= wbss_pkg::LEN_W'(1);
			offset_q   <= '0;
			relative_q <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				wbss_pkg::REG_PATTERN_LOW:    pat_q[0]   <= pwdata;
				wbss_pkg::REG_PATTERN_SECOND: pat_q[1]   <= pwdata;
				wbss_pkg::REG_PATTERN_THIRD:  pat_q[2]   <= pwdata;
				wbss_pkg::REG_PATTERN_HIGH:   pat_q[3]   <= pwdata;
				wbss_pkg::REG_WILDCARD_MASK:  wild_q     <= pwdata[31:0];
				wbss_pkg::REG_PATTERN_LENGTH: len_q      <= pwdata[wbss_pkg::LEN_W-1:0];
				wbss_pkg::REG_OPERAND_OFFSET: offset_q   <= pwdata[wbss_pkg::OFFS_W-1:0];
				wbss_pkg::REG_RELATIVE_MODE:  relative_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			wbss_pkg::REG_PATTERN_LOW:    prdata = pat_q[0];
			wbss_pkg::REG_PATTERN_SECOND: prdata = pat_q[1];
			wbss_pkg::REG_PATTERN_THIRD:  prdata = pat_q[2];
			wbss_pkg::REG_PATTERN_HIGH:   prdata = pat_q[3];
			wbss_pkg::REG_WILDCARD_MASK:  prdata = 64'(wild_q);
			wbss_pkg::REG_PATTERN_LENGTH: prdata = 64'(len_q);
			wbss_pkg::REG_OPERAND_OFFSET: prdata = 64'(offset_q);
			wbss_pkg::REG_RELATIVE_MODE:  prdata = 64'(relative_q);
			default:                      prdata = '0;
		endcase
	end

	// effective length: zero acts as one, anything above the window as full window
	wbss_pkg::scan_cfg_t cfg;
	always_comb begin
		cfg.pattern  = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};
		cfg.wild     = wild_q;
		cfg.offset   = offset_q;
		cfg.relative = relative_q;
		if (len_q == '0) begin
			cfg.eff_len = wbss_pkg::LEN_W'(1);
		end else if (len_q > wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN)) begin
			cfg.eff_len = wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN);
		end else begin
			cfg.eff_len = len_q;
		end
	end

	// ---------------- input register ----------------
	logic                          valid_s1;
	logic [7:0]                    data_s1;
	logic [wbss_pkg::ADDR_W-1:0]   addr_s1;
	logic                          last_s1;
	logic                          adv_s1;
	logic                          s_fire;

	// s1 moves on when the output register is empty or being drained
	assign adv_s1   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			data_s1 <= s_tdata[7:0];
			addr_s1 <= s_tdata[39:8];
			last_s1 <= s_tlast;
		end
	end

	// ---------------- scan state ----------------
	// window holds payload only: every byte read in a compare was written in this scan
	logic [7:0]                 win_q   [wbss_pkg::MAX_PATTERN];
	logic [7:0]                 win_nxt [wbss_pkg::MAX_PATTERN];
	logic [wbss_pkg::LEN_W-1:0] seen_q;
	logic [wbss_pkg::LEN_W-1:0] seen_nxt;
	logic                       done_q;

	always_comb begin
		win_nxt[0] = data_s1;
		for (int k = 1; k < wbss_pkg::MAX_PATTERN; k++) win_nxt[k] = win_q[k-1];
	end

	// saturating byte count of the current scan
	assign seen_nxt = (seen_q == wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN)) ? seen_q
		: seen_q + wbss_pkg::LEN_W'(1);

	wbss_pkg::match_res_t mres;

	wbss_match u_match (
		.win          (win_nxt),
		.cfg          (cfg),
		.byte_address (addr_s1),
		.res          (mres)
	);

	// first hit of a scan, or end of scan without any hit
	logic match_now;
	logic miss_end;
	assign match_now = !done_q && (seen_nxt >= cfg.eff_len) && mres.hit;
	assign miss_end  = last_s1 && !done_q && !match_now;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int k = 0; k < wbss_pkg::MAX_PATTERN; k++) win_q[k] <= win_nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			done_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				// scan over: start fresh
				seen_q <= '0;
				done_q <= 1'b0;
			end else begin
				seen_q <= seen_nxt;
				done_q <= done_q || match_now;
			end
		end
	end

	// ---------------- result register ----------------
	logic                        found_q;
	logic [wbss_pkg::ADDR_W-1:0] op_addr_q;
	logic [31:0]                 op_value_q;
	logic                        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= match_now || miss_end;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (match_now || miss_end)) begin
			found_q    <= match_now;
			op_addr_q  <= match_now ? mres.op_addr  : '0;
			op_value_q <= match_now ? mres.op_value : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {op_value_q, op_addr_q};

	// ---------------- checks ----------------
	`WBSS_ASSERT_NOW(a_notfound_zero, m_tvalid && !m_tuser, m_tdata == 64'd0,
		"not-found result carries nonzero payload")
	`WBSS_ASSERT_NEXT(a_last_clears, adv_s1 && last_s1, seen_q == '0 && !done_q,
		"scan state not cleared after last byte")
	`WBSS_ASSERT_NOW(a_seen_sat, 1'b1, seen_q <= wbss_pkg::LEN_W'(wbss_pkg::MAX_PATTERN),
		"byte count past window depth")
	`WBSS_ASSERT_NEXT(a_no_second_hit, adv_s1 && done_q && !last_s1, !done_q || !match_now,
		"second match reported in one scan")

endmodule

// File: src/wbss_match.sv
// masked window compare and operand extraction for one byte
module wbss_match (
	input  logic [7:0]                    win [wbss_pkg::MAX_PATTERN],  // [0] newest
	input  wbss_pkg::scan_cfg_t           cfg,
	input  logic [wbss_pkg::ADDR_W-1:0]   byte_address,
	output wbss_pkg::match_res_t          res
);

	logic [wbss_pkg::MAX_PATTERN-1:0] byte_ok;
	logic [wbss_pkg::ADDR_W-1:0]      start_addr;
	logic [wbss_pkg::ADDR_W-1:0]      op_addr;
	logic [31:0]                      operand;
	logic                             op_inside;
	logic [wbss_pkg::LEN_W:0]         op_end;

	// pattern byte i sits at window position eff_len-1-i
	always_comb begin
		logic [wbss_pkg::LEN_W-1:0] pos;
		for (int i = 0; i < wbss_pkg::MAX_PATTERN; i++) begin
			pos = cfg.eff_len - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(i);
			if (wbss_pkg::LEN_W'(i) >= cfg.eff_len || cfg.wild[i]) begin
				byte_ok[i] = 1'b1;
			end else begin
				byte_ok[i] = (cfg.pattern[i*8 +: 8] == win[pos[wbss_pkg::WIN_IDX_W-1:0]]);
			end
		end
	end

	// operand bytes, little-endian from window offset
	always_comb begin
		logic [wbss_pkg::LEN_W-1:0] pos;
		operand = '0;
		for (int j = 0; j < wbss_pkg::OPERAND_BYTES; j++) begin
			pos = cfg.eff_len - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(cfg.offset)
				- wbss_pkg::LEN_W'(j);
			operand[j*8 +: 8] = win[pos[wbss_pkg::WIN_IDX_W-1:0]];
		end
	end

	assign op_end     = (wbss_pkg::LEN_W+1)'(cfg.offset) + (wbss_pkg::LEN_W+1)'(wbss_pkg::OPERAND_BYTES);
	assign op_inside  = (op_end <= (wbss_pkg::LEN_W+1)'(cfg.eff_len));
	assign start_addr = byte_address - wbss_pkg::ADDR_W'(cfg.eff_len) + wbss_pkg::ADDR_W'(1);
	assign op_addr    = start_addr + wbss_pkg::ADDR_W'(cfg.offset);

	always_comb begin
		res.hit     = &byte_ok;
		res.op_addr = op_addr;
		if (!op_inside) begin
			res.op_value = '0;
		end else if (cfg.relative) begin
			res.op_value = operand + op_addr + 32'd4;
		end else begin
			res.op_value = operand;
		end
	end

endmodule
